// File: rtl/bpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

   // Bitmap word geometry: one 64-bit word per memory row.
   localparam int WORD_BITS   = 64;
   localparam int BIT_IDX_W   = 6;
   localparam int ADDR_W      = 32;
   localparam int PAGE_ADDR_W = 24;
   localparam int STATUS_W    = 2;

   // Request codes.
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN_FIRST,
      ST_SCAN,
      ST_FREE_RD,
      ST_FREE_EVAL,
      ST_DONE
   } bpa_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clr_wr;
      logic accept;
      logic scan_rd;
      logic alloc_hit;
      logic alloc_full;
      logic free_rd;
      logic free_bad;
      logic free_eval;
      logic load_out;
   } bpa_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clr_last;
      logic word_has_zero;
      logic chk_last;
      logic free_in_range;
      logic out_free;
   } bpa_stat_type;

   // Index of the lowest clear bit of a bitmap word.
   function automatic logic [BIT_IDX_W-1:0] first_zero(input logic [WORD_BITS-1:0] w);
      logic [BIT_IDX_W-1:0] idx;
      idx = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (!w[b]) begin
            idx = BIT_IDX_W'(b);
         end
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

// File: rtl/bpa_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bpa_req_if;
   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic [bpa_pkg::ADDR_W-1:0]    free_addr;

   modport source (output valid, req_type, free_addr, input ready);
   modport sink   (input valid, req_type, free_addr, output ready);
endinterface

interface bpa_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [bpa_pkg::STATUS_W-1:0]    status;
   logic [bpa_pkg::PAGE_ADDR_W-1:0] page_addr;

   modport source (output valid, status, page_addr, input ready);
   modport sink   (input valid, status, page_addr, output ready);
endinterface

`default_nettype wire

// File: rtl/bitmap_page_allocator.sv
// Bitmap first-fit page allocator.
// The req channel carries one request per transfer: req_type selects an
// allocate or a free, and free_addr gives the byte address to free. The rsp
// channel returns exactly one transfer per request with a status (ok, no free
// page, or invalid free) and the byte address of the allocated page.
// The used-page bitmap sits in a memory of 64-bit words, one read and one
// write port. An allocate scans it one word per cycle from word zero and
// stops at the first word with a clear bit, or after the last word with no
// free page. A free of a page inside the pool reads its word and clears the
// page's bit; a free past the end of the pool answers without a read. The
// block takes one request at a time; the next request is taken the cycle
// after the result is loaded into the output register.
// After reset a clearing pass writes the reset image into every word, one
// word per cycle, with req ready held low; the first RESERVED_PAGES pages
// come out of it marked used.
// A stalled receiver holds the result in the output register; the block
// finishes the current request and waits there until the transfer happens.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_page_allocator #(
   parameter int NUM_PAGES      = 4096,
   parameter int PAGE_BYTES     = 4096,
   parameter int RESERVED_PAGES = 16
) (
   input wire logic clock,
   input wire logic reset,
   bpa_req_if.sink  req_ch,
   bpa_rsp_if.source rsp_ch
);

   bpa_pkg::bpa_cmd_type  cmd;
   bpa_pkg::bpa_stat_type stat;
   logic                  req_ready;

   // The controller sequences the clearing pass, the word scan and the
   // read-modify-write of a free; it sees the datapath only through the
   // command and status structs.
   bpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_type  (req_ch.req_type),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the bitmap memory, the scan pointers, the captured
   // request and the output register.
   bpa_dp #(
      .NUM_PAGES      (NUM_PAGES),
      .PAGE_BYTES     (PAGE_BYTES),
      .RESERVED_PAGES (RESERVED_PAGES)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_type      (req_ch.req_type),
      .free_addr     (req_ch.free_addr),
      .rsp_ready     (rsp_ch.ready),
      .rsp_valid     (rsp_ch.valid),
      .rsp_status    (rsp_ch.status),
      .rsp_page_addr (rsp_ch.page_addr)
   );

   assign req_ch.ready = req_ready;

endmodule

`default_nettype wire

// File: rtl/bpa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bpa_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_type,
   output logic                       req_ready,
   input  wire bpa_pkg::bpa_stat_type stat,
   output bpa_pkg::bpa_cmd_type       cmd
);

   bpa_pkg::bpa_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bpa_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bpa_pkg::ST_CLEAR: begin
            if (stat.clr_last) state_in = bpa_pkg::ST_IDLE;
         end
         bpa_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_type == bpa_pkg::REQ_FREE) ? bpa_pkg::ST_FREE_RD
                                                          : bpa_pkg::ST_SCAN_FIRST;
            end
         end
         bpa_pkg::ST_SCAN_FIRST: state_in = bpa_pkg::ST_SCAN;
         bpa_pkg::ST_SCAN: begin
            if (stat.word_has_zero || stat.chk_last) state_in = bpa_pkg::ST_DONE;
         end
         bpa_pkg::ST_FREE_RD: begin
            state_in = stat.free_in_range ? bpa_pkg::ST_FREE_EVAL : bpa_pkg::ST_DONE;
         end
         bpa_pkg::ST_FREE_EVAL: state_in = bpa_pkg::ST_DONE;
         bpa_pkg::ST_DONE: begin
            if (stat.out_free) state_in = bpa_pkg::ST_IDLE;
         end
         default: state_in = bpa_pkg::ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         bpa_pkg::ST_CLEAR: cmd.clr_wr = 1'b1;
         bpa_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         bpa_pkg::ST_SCAN_FIRST: cmd.scan_rd = 1'b1;
         bpa_pkg::ST_SCAN: begin
            if (stat.word_has_zero) begin
               cmd.alloc_hit = 1'b1;
            end else if (stat.chk_last) begin
               cmd.alloc_full = 1'b1;
            end else begin
               cmd.scan_rd = 1'b1;
            end
         end
         bpa_pkg::ST_FREE_RD: begin
            cmd.free_rd  = stat.free_in_range;
            cmd.free_bad = !stat.free_in_range;
         end
         bpa_pkg::ST_FREE_EVAL: cmd.free_eval = 1'b1;
         bpa_pkg::ST_DONE: cmd.load_out = stat.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/bpa_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module bpa_dp #(
   parameter int NUM_PAGES      = 4096,
   parameter int PAGE_BYTES     = 4096,
   parameter int RESERVED_PAGES = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire bpa_pkg::bpa_cmd_type            cmd,
   output bpa_pkg::bpa_stat_type                stat,
   input  wire logic                            req_type,
   input  wire logic [bpa_pkg::ADDR_W-1:0]      free_addr,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_valid,
   output logic [bpa_pkg::STATUS_W-1:0]         rsp_status,
   output logic [bpa_pkg::PAGE_ADDR_W-1:0]      rsp_page_addr
);

   localparam int WORDS  = (NUM_PAGES + bpa_pkg::WORD_BITS - 1) / bpa_pkg::WORD_BITS;
   localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int IW     = AW + bpa_pkg::BIT_IDX_W;
   localparam int PSHIFT = $clog2(PAGE_BYTES);
   localparam int WB     = bpa_pkg::WORD_BITS;

   logic [WB-1:0] mem [WORDS];

   logic [WB-1:0]                   rd_data_ff;
   logic [AW-1:0]                   ptr_ff, ptr_in;
   logic [AW-1:0]                   chk_ptr_ff;
   logic [IW-1:0]                   free_idx_ff;
   logic                            free_in_range_ff;
   logic [bpa_pkg::STATUS_W-1:0]    res_status_ff;
   logic [bpa_pkg::PAGE_ADDR_W-1:0] res_addr_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [bpa_pkg::STATUS_W-1:0]    rsp_status_ff;
   logic [bpa_pkg::PAGE_ADDR_W-1:0] rsp_page_addr_ff;

   logic                            wr_en;
   logic [AW-1:0]                   wr_addr;
   logic [WB-1:0]                   wr_data;
   logic                            rd_en;
   logic [AW-1:0]                   rd_addr;
   logic [bpa_pkg::BIT_IDX_W-1:0]   hit_bit;
   logic [63:0]                     alloc_addr_wide;
   logic [bpa_pkg::ADDR_W-1:0]      idx_full;
   logic [AW-1:0]                   free_word;
   logic [bpa_pkg::BIT_IDX_W-1:0]   free_bit;
   logic                            free_bit_set;

   // Reset image of one bitmap word: reserved pages and pages past the end
   // of the bitmap read as used, so the scan never hands them out.
   function automatic logic [WB-1:0] init_word(input logic [AW-1:0] w);
      logic [WB-1:0] v;
      int unsigned   pg;
      v = '0;
      for (int b = 0; b < WB; b++) begin
         pg   = int'(w) * WB + b;
         v[b] = (pg < RESERVED_PAGES) || (pg >= NUM_PAGES);
      end
      return v;
   endfunction

   assign hit_bit         = bpa_pkg::first_zero(rd_data_ff);
   assign alloc_addr_wide = 64'({chk_ptr_ff, hit_bit}) << PSHIFT;
   assign idx_full        = free_addr >> PSHIFT;
   assign free_word       = free_idx_ff[IW-1:bpa_pkg::BIT_IDX_W];
   assign free_bit        = free_idx_ff[bpa_pkg::BIT_IDX_W-1:0];
   assign free_bit_set    = rd_data_ff[free_bit];

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ptr_ff;
      wr_data = init_word(ptr_ff);
      priority if (cmd.clr_wr) begin
         wr_en = 1'b1;
      end else if (cmd.alloc_hit) begin
         wr_en   = 1'b1;
         wr_addr = chk_ptr_ff;
         wr_data = rd_data_ff | (WB'(1) << hit_bit);
      end else if (cmd.free_eval) begin
         wr_en   = free_bit_set;
         wr_addr = free_word;
         wr_data = rd_data_ff & ~(WB'(1) << free_bit);
      end
   end

   assign rd_en   = cmd.scan_rd || cmd.free_rd;
   assign rd_addr = cmd.free_rd ? free_word : ptr_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      ptr_in = ptr_ff;
      priority if (cmd.accept) begin
         ptr_in = '0;
      end else if (cmd.clr_wr || cmd.scan_rd) begin
         ptr_in = ptr_ff + AW'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.scan_rd) chk_ptr_ff <= ptr_ff;
      if (cmd.accept) begin
         free_idx_ff      <= idx_full[IW-1:0];
         free_in_range_ff <= (req_type == bpa_pkg::REQ_FREE) &&
                             (idx_full < bpa_pkg::ADDR_W'(NUM_PAGES));
      end
      priority if (cmd.alloc_hit) begin
         res_status_ff <= bpa_pkg::STATUS_OK;
         res_addr_ff   <= alloc_addr_wide[bpa_pkg::PAGE_ADDR_W-1:0];
      end else if (cmd.alloc_full || cmd.free_bad) begin
         res_status_ff <= cmd.alloc_full ? bpa_pkg::STATUS_FULL : bpa_pkg::STATUS_INVALID;
         res_addr_ff   <= '0;
      end else if (cmd.free_eval) begin
         res_status_ff <= free_bit_set ? bpa_pkg::STATUS_OK : bpa_pkg::STATUS_INVALID;
         res_addr_ff   <= '0;
      end
      if (cmd.load_out) begin
         rsp_status_ff    <= res_status_ff;
         rsp_page_addr_ff <= res_addr_ff;
      end
   end

   assign stat.clr_last      = (ptr_ff == AW'(WORDS - 1));
   assign stat.word_has_zero = ~&rd_data_ff;
   assign stat.chk_last      = (chk_ptr_ff == AW'(WORDS - 1));
   assign stat.free_in_range = free_in_range_ff;
   assign stat.out_free      = !rsp_valid_ff || rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_page_addr = rsp_page_addr_ff;

endmodule

`default_nettype wire

// File: rtl/bpa_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module bpa_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_ready,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic [bpa_pkg::STATUS_W-1:0]        rsp_status,
   input wire logic [bpa_pkg::PAGE_ADDR_W-1:0]     rsp_page_addr
);

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_page_addr))
      else $error("rsp changed while stalled");

   // Only the three defined status codes appear.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == bpa_pkg::STATUS_OK) ||
                    (rsp_status == bpa_pkg::STATUS_FULL) ||
                    (rsp_status == bpa_pkg::STATUS_INVALID))
      else $error("undefined status code");

   // Failed requests never carry an address.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != bpa_pkg::STATUS_OK) |-> rsp_page_addr == '0)
      else $error("address on failed request");

   // Page addresses are page aligned (pages are at least 256 bytes).
   a_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_page_addr[7:0] == 8'd0)
      else $error("unaligned page address");

   // The clearing pass follows reset, so no request is taken right after it.
   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_ready)
      else $error("request taken during clearing pass");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_status    (rsp_ch.status),
   .rsp_page_addr (rsp_ch.page_addr)
);

`default_nettype wire
